>>> rtl/core/thick_ellipse_point_stepper_macros.svh
// Assertion helpers for the ellipse stepper checker.
`ifndef THICK_ELLIPSE_POINT_STEPPER_MACROS_SVH
`define THICK_ELLIPSE_POINT_STEPPER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TEP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tep assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TEP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tep assertion failed");

`endif

>>> rtl/core/tep_pkg.sv
package tep_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int CFG_IDX_W      = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_XA = 3'd0,
    CFG_BOX_YA = 3'd1,
    CFG_BOX_XB = 3'd2,
    CFG_BOX_YB = 3'd3,
    CFG_THICK  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REG_ONE  = 2'd0,
    REG_TWO  = 2'd1,
    REG_DONE = 2'd2
  } region_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD,
    OP_SQRX, OP_SQRY, OP_SQRIX, OP_SQRIY, OP_PYO, OP_PYI,
    OP_XXO, OP_AO, OP_YYO, OP_BO, OP_CO,
    OP_XXI, OP_AI, OP_YYI, OP_BI, OP_CI,
    OP_R1A, OP_R1B, OP_R2A, OP_R2B,
    OP_SET_R2, OP_SET_DONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   capture;
  } dp_cmd_t;

  typedef struct packed {
    region_t region;
    logic    o_flat;
    logic    o_y_zero;
  } dp_stat_t;

endpackage

>>> rtl/core/tep_if.sv
interface tep_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface tep_out_if import tep_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS:0]   center_x_twice;
  logic [COORD_BITS:0]   center_y_twice;
  logic [COORD_BITS-2:0] outer_dx;
  logic [COORD_BITS-2:0] outer_dy;
  logic [COORD_BITS-2:0] inner_dx;
  logic [COORD_BITS-2:0] inner_dy;
  logic                  last;
  modport source (output valid, output center_x_twice, output center_y_twice,
                  output outer_dx, output outer_dy, output inner_dx, output inner_dy,
                  output last, input ready);
  modport sink (input valid, input center_x_twice, input center_y_twice,
                input outer_dx, input outer_dy, input inner_dx, input inner_dy,
                input last, output ready);
endinterface

>>> rtl/core/tep_ctrl.sv
module tep_ctrl import tep_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_restart,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_LOAD = 9'b000000010,
    S_SQ   = 9'b000000100,
    S_CHK  = 9'b000001000,
    S_ENT  = 9'b000010000,
    S_ENTF = 9'b000100000,
    S_STA  = 9'b001000000,
    S_STB  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  localparam logic [3:0] SQ_LAST  = 4'd5;
  localparam logic [3:0] ENT_LAST = 4'd9;

  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd.op        = OP_NONE;
    cmd.capture   = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          if (in_restart) begin
            state_nxt = S_LOAD;
          end else begin
            case (stat.region)
              REG_ONE: state_nxt = stat.o_flat ? S_ENT : S_STA;
              REG_TWO: begin
                if (stat.o_y_zero) begin
                  cmd.op    = OP_SET_DONE;
                  state_nxt = S_OUT;
                end else begin
                  state_nxt = S_STA;
                end
              end
              default: state_nxt = S_OUT;
            endcase
          end
        end
      end
      S_LOAD: begin
        cmd.op    = OP_LOAD;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        case (cnt_r)
          4'd0:    cmd.op = OP_SQRX;
          4'd1:    cmd.op = OP_SQRY;
          4'd2:    cmd.op = OP_SQRIX;
          4'd3:    cmd.op = OP_SQRIY;
          4'd4:    cmd.op = OP_PYO;
          default: cmd.op = OP_PYI;
        endcase
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == SQ_LAST) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        cnt_nxt   = '0;
        state_nxt = stat.o_flat ? S_ENT : S_OUT;
      end
      S_ENT: begin
        case (cnt_r)
          4'd0:    cmd.op = OP_XXO;
          4'd1:    cmd.op = OP_AO;
          4'd2:    cmd.op = OP_YYO;
          4'd3:    cmd.op = OP_BO;
          4'd4:    cmd.op = OP_CO;
          4'd5:    cmd.op = OP_XXI;
          4'd6:    cmd.op = OP_AI;
          4'd7:    cmd.op = OP_YYI;
          4'd8:    cmd.op = OP_BI;
          default: cmd.op = OP_CI;
        endcase
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == ENT_LAST) begin
          state_nxt = S_ENTF;
        end
      end
      S_ENTF: begin
        cmd.op    = OP_SET_R2;
        state_nxt = S_OUT;
      end
      S_STA: begin
        cmd.op    = (stat.region == REG_ONE) ? OP_R1A : OP_R2A;
        state_nxt = S_STB;
      end
      S_STB: begin
        cmd.op    = (stat.region == REG_ONE) ? OP_R1B : OP_R2B;
        state_nxt = (stat.region == REG_ONE) ? S_CHK : S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.capture   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/core/tep_datapath.sv
module tep_datapath import tep_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [COORD_BITS-1:0] cfg_wdata,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic [COORD_BITS:0]   o_cx,
  output logic [COORD_BITS:0]   o_cy,
  output logic [COORD_BITS-2:0] o_odx,
  output logic [COORD_BITS-2:0] o_ody,
  output logic [COORD_BITS-2:0] o_idx,
  output logic [COORD_BITS-2:0] o_idy,
  output logic                  o_last
);

  localparam int CB  = COORD_BITS;
  localparam int OW  = CB - 1;
  localparam int CW  = CB + 1;
  localparam int SQW = 2 * CB - 2;
  localparam int SLW = 3 * CB;
  localparam int DW  = 4 * CB;
  localparam int MW  = 2 * CB + 1;

  logic [CB-1:0] xa_r, ya_r, xb_r, yb_r, th_r;
  logic [OW-1:0] rx_r, ry_r, rix_r, riy_r;
  logic [CW-1:0] cen_x_r, cen_y_r;
  logic [SQW-1:0] sq_rx_r, sq_ry_r, sq_rix_r, sq_riy_r;
  logic [CB-1:0] x_o_r, y_o_r, x_i_r, y_i_r;
  logic signed [SLW-1:0] px_o_r, py_o_r, px_i_r, py_i_r;
  logic signed [DW-1:0] p_o_r, p_i_r, acc_r, prod_r;
  dp_op_t  wb_op_r;
  region_t region_r;
  logic    go_i_r;

  // box setup
  logic [CB-1:0] xlo, xhi, ylo, yhi, dxw, dyw, shrink;
  logic [OW-1:0] rx, ry, rix, riy;
  always_comb begin
    xlo    = (xa_r < xb_r) ? xa_r : xb_r;
    xhi    = (xa_r < xb_r) ? xb_r : xa_r;
    ylo    = (ya_r < yb_r) ? ya_r : yb_r;
    yhi    = (ya_r < yb_r) ? yb_r : ya_r;
    dxw    = xhi - xlo;
    dyw    = yhi - ylo;
    rx     = dxw[CB-1:1];
    ry     = dyw[CB-1:1];
    shrink = (th_r != '0) ? th_r - CB'(1) : '0;
    rix    = ({1'b0, rx} > shrink) ? OW'({1'b0, rx} - shrink) : '0;
    riy    = ({1'b0, ry} > shrink) ? OW'({1'b0, ry} - shrink) : '0;
  end

  // shared multiplier, product registered
  logic signed [MW-1:0]   mul_a, mul_b, prod_lo;
  logic signed [2*MW-1:0] prod_full;
  assign prod_lo = prod_r[MW-1:0];
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SQRX:  begin mul_a = MW'(rx_r);     mul_b = MW'(rx_r);               end
      OP_SQRY:  begin mul_a = MW'(ry_r);     mul_b = MW'(ry_r);               end
      OP_SQRIX: begin mul_a = MW'(rix_r);    mul_b = MW'(rix_r);              end
      OP_SQRIY: begin mul_a = MW'(riy_r);    mul_b = MW'(riy_r);              end
      OP_PYO:   begin mul_a = MW'(sq_rx_r);  mul_b = MW'(ry_r);               end
      OP_PYI:   begin mul_a = MW'(sq_rix_r); mul_b = MW'(riy_r);              end
      OP_XXO:   begin mul_a = MW'(x_o_r);    mul_b = MW'(x_o_r);              end
      OP_AO:    begin mul_a = MW'(sq_ry_r);  mul_b = prod_lo;                 end
      OP_YYO:   begin mul_a = MW'(y_o_r);    mul_b = MW'(y_o_r) - MW'(1);     end
      OP_BO:    begin mul_a = MW'(sq_rx_r);  mul_b = prod_lo;                 end
      OP_CO:    begin mul_a = MW'(sq_rx_r);  mul_b = MW'(sq_ry_r);            end
      OP_XXI:   begin mul_a = MW'(x_i_r);    mul_b = MW'(x_i_r);              end
      OP_AI:    begin mul_a = MW'(sq_riy_r); mul_b = prod_lo;                 end
      OP_YYI:   begin mul_a = MW'(y_i_r);    mul_b = MW'(y_i_r) - MW'(1);     end
      OP_BI:    begin mul_a = MW'(sq_rix_r); mul_b = prod_lo;                 end
      OP_CI:    begin mul_a = MW'(sq_rix_r); mul_b = MW'(sq_riy_r);           end
      default:  begin mul_a = '0;            mul_b = '0;                      end
    endcase
  end
  assign prod_full = mul_a * mul_b;

  logic [SLW-1:0] dsq_rx, dsq_ry, dsq_rix, dsq_riy;
  assign dsq_rx  = {{(SLW-SQW-1){1'b0}}, sq_rx_r, 1'b0};
  assign dsq_ry  = {{(SLW-SQW-1){1'b0}}, sq_ry_r, 1'b0};
  assign dsq_rix = {{(SLW-SQW-1){1'b0}}, sq_rix_r, 1'b0};
  assign dsq_riy = {{(SLW-SQW-1){1'b0}}, sq_riy_r, 1'b0};

  logic o_neg, i_neg, o_pos, i_pos;
  assign o_neg = p_o_r[DW-1];
  assign i_neg = p_i_r[DW-1];
  assign o_pos = !o_neg && (p_o_r != '0);
  assign i_pos = !i_neg && (p_i_r != '0);

  assign stat.region   = region_r;
  assign stat.o_flat   = !(px_o_r < py_o_r);
  assign stat.o_y_zero = (y_o_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xa_r <= '0; ya_r <= '0; xb_r <= '0; yb_r <= '0; th_r <= CB'(1);
      rx_r <= '0; ry_r <= '0; rix_r <= '0; riy_r <= '0;
      cen_x_r <= '0; cen_y_r <= '0;
      sq_rx_r <= '0; sq_ry_r <= '0; sq_rix_r <= '0; sq_riy_r <= '0;
      x_o_r <= '0; y_o_r <= '0; x_i_r <= '0; y_i_r <= '0;
      px_o_r <= '0; py_o_r <= '0; px_i_r <= '0; py_i_r <= '0;
      p_o_r <= '0; p_i_r <= '0; acc_r <= '0; prod_r <= '0;
      wb_op_r <= OP_NONE;
      region_r <= REG_ONE;
      go_i_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_BOX_XA: xa_r <= cfg_wdata;
          CFG_BOX_YA: ya_r <= cfg_wdata;
          CFG_BOX_XB: xb_r <= cfg_wdata;
          CFG_BOX_YB: yb_r <= cfg_wdata;
          CFG_THICK:  th_r <= cfg_wdata;
          default: ;
        endcase
      end

      prod_r  <= prod_full[DW-1:0];
      wb_op_r <= cmd.op;

      // write back the product issued last cycle
      case (wb_op_r)
        OP_SQRX:  sq_rx_r  <= prod_r[SQW-1:0];
        OP_SQRY:  sq_ry_r  <= prod_r[SQW-1:0];
        OP_SQRIX: sq_rix_r <= prod_r[SQW-1:0];
        OP_SQRIY: sq_riy_r <= prod_r[SQW-1:0];
        OP_PYO: begin
          py_o_r <= {prod_r[SLW-2:0], 1'b0};
          p_o_r  <= DW'(sq_ry_r) - prod_r + DW'(sq_rx_r >> 2);
        end
        OP_PYI: begin
          py_i_r <= {prod_r[SLW-2:0], 1'b0};
          p_i_r  <= DW'(sq_riy_r) - prod_r + DW'(sq_rix_r >> 2);
        end
        OP_AO, OP_AI: acc_r <= prod_r;
        OP_BO, OP_BI: acc_r <= acc_r + prod_r;
        OP_CO: p_o_r <= acc_r + DW'(sq_rx_r >> 2) - prod_r;
        OP_CI: p_i_r <= acc_r + DW'(sq_rix_r >> 2) - prod_r;
        default: ;
      endcase

      case (cmd.op)
        OP_LOAD: begin
          rx_r <= rx; ry_r <= ry; rix_r <= rix; riy_r <= riy;
          cen_x_r <= {1'b0, xlo} + {1'b0, xhi};
          cen_y_r <= {1'b0, ylo} + {1'b0, yhi};
          x_o_r <= '0; y_o_r <= CB'(ry);
          x_i_r <= '0; y_i_r <= CB'(riy);
          px_o_r <= '0; px_i_r <= '0;
          region_r <= REG_ONE;
        end
        OP_R1A: begin
          x_o_r  <= x_o_r + CB'(1);
          px_o_r <= px_o_r + dsq_ry;
          if (!o_neg) begin
            y_o_r  <= y_o_r - CB'(1);
            py_o_r <= py_o_r - dsq_rx;
          end
          go_i_r <= (px_i_r < py_i_r);
          if (px_i_r < py_i_r) begin
            x_i_r  <= x_i_r + CB'(1);
            px_i_r <= px_i_r + dsq_riy;
            if (!i_neg) begin
              y_i_r  <= y_i_r - CB'(1);
              py_i_r <= py_i_r - dsq_rix;
            end
          end
        end
        OP_R1B: begin
          p_o_r <= p_o_r + DW'(sq_ry_r) + DW'(px_o_r) - (o_neg ? '0 : DW'(py_o_r));
          if (go_i_r) begin
            p_i_r <= p_i_r + DW'(sq_riy_r) + DW'(px_i_r) - (i_neg ? '0 : DW'(py_i_r));
          end
        end
        OP_R2A: begin
          y_o_r  <= y_o_r - CB'(1);
          py_o_r <= py_o_r - dsq_rx;
          if (!o_pos) begin
            x_o_r  <= x_o_r + CB'(1);
            px_o_r <= px_o_r + dsq_ry;
          end
          go_i_r <= (y_i_r != '0);
          if (y_i_r != '0) begin
            y_i_r  <= y_i_r - CB'(1);
            py_i_r <= py_i_r - dsq_rix;
            if (!i_pos) begin
              x_i_r  <= x_i_r + CB'(1);
              px_i_r <= px_i_r + dsq_riy;
            end
          end
        end
        OP_R2B: begin
          p_o_r <= p_o_r + DW'(sq_rx_r) - DW'(py_o_r) + (o_pos ? '0 : DW'(px_o_r));
          if (go_i_r) begin
            p_i_r <= p_i_r + DW'(sq_rix_r) - DW'(py_i_r) + (i_pos ? '0 : DW'(px_i_r));
          end
        end
        OP_SET_R2:   region_r <= REG_TWO;
        OP_SET_DONE: region_r <= REG_DONE;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      o_cx   <= cen_x_r;
      o_cy   <= cen_y_r;
      o_odx  <= x_o_r[OW-1:0];
      o_ody  <= y_o_r[OW-1:0];
      o_idx  <= x_i_r[OW-1:0];
      o_idy  <= y_i_r[OW-1:0];
      o_last <= (region_r != REG_ONE) && (y_o_r == '0);
    end
  end

endmodule

>>> rtl/core/thick_ellipse_point_stepper.sv
// Sequence (accept to out valid): restart loads, runs six multiplies and checks, and if
//   the box is flat at once runs ten more multiplies, then outputs; region one step: both
//   step phases and a check; region two step: both step phases, or done at y zero; past
//   end: output; crossing into region two, as a first step from reset does, adds ten more
//   multiplies. One transaction at a time; the next is taken after the result is parked.
// Reset: rst_n synchronous, active low; clears config (thickness to 1),
//   walker state to zero in region one, and the output valid.
module thick_ellipse_point_stepper import tep_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tep_in_if.sink                in_ch,
  tep_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [COORD_BITS-1:0] cfg_wdata
);

  // Controller and datapath talk only through these two structs.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer: accepts a transaction in idle, walks the multiply
  // schedule or the step phases, then parks the result in the output
  // register. A new transaction may start while that result waits.
  tep_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_restart (in_ch.restart),
    .in_ready   (in_ch.ready),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath: config regs, both walkers, one shared multiplier with
  // registered product, and the output register.
  tep_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .o_cx      (out_ch.center_x_twice),
    .o_cy      (out_ch.center_y_twice),
    .o_odx     (out_ch.outer_dx),
    .o_ody     (out_ch.outer_dy),
    .o_idx     (out_ch.inner_dx),
    .o_idy     (out_ch.inner_dy),
    .o_last    (out_ch.last)
  );

endmodule

>>> rtl/core/tep_checker.sv
`include "thick_ellipse_point_stepper_macros.svh"

module tep_checker import tep_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-2:0] out_outer_dx,
  input logic [COORD_BITS-2:0] out_outer_dy,
  input logic                  out_last
);

  // pending result holds
  `TEP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_outer_dx) && $stable(out_outer_dy))
  // one transaction at a time
  `TEP_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // last only at outer dy zero
  `TEP_ASSERT_IMP(a_last_dy, out_valid && out_last, out_outer_dy == '0)

endmodule

bind thick_ellipse_point_stepper tep_checker #(.COORD_BITS(COORD_BITS)) u_tep_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_outer_dx (out_ch.outer_dx),
  .out_outer_dy (out_ch.outer_dy),
  .out_last     (out_ch.last)
);
